[src/bounded_deque_with_positional_delete_macros.svh]
// ----------------------------------------------------------------------------
// bounded deque assertion macros
// shared assertion shorthands for the deque block
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_POSITIONAL_DELETE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_POSITIONAL_DELETE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// types and codes for the bounded deque with positional delete
// ----------------------------------------------------------------------------
package bdq_pkg;

  // default capacity in words
  localparam int DEPTH_DEF = 64;

  // operation codes
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MODE_POP_BACK   = 3'd2;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [2:0] MODE_POP_AT     = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // word returned by a failed removal (+infinity of a double)
  localparam logic [63:0] INF_WORD = 64'h7FF0_0000_0000_0000;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RD    = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

endpackage

[src/bounded_deque_with_positional_delete.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_delete
// ring-buffer deque of 64-bit words with removal at a 1-based position
// ----------------------------------------------------------------------------
// Words live in one synchronous ring memory addressed from a head pointer.
// A transaction is taken when start is high and busy is low; its result shows
// on the out_ ports for one cycle under out_valid, and the receiver must take
// it then. Inserts (and any refused or failed operation) show their result in
// the next cycle. Removal from the back or the front passes through S_RD for
// the registered memory read. Removal at position p with n entries stored goes
// through S_RD and then, if n > p, S_SHIFT: the n - p entries behind it are
// moved forward one per cycle through the memory's one read and one write port.
`include "bounded_deque_with_positional_delete_macros.svh"

module bounded_deque_with_positional_delete
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_value,
  input  logic [6:0]  in_position,
  output logic        out_valid,
  output logic [63:0] out_removed_value,
  output logic [1:0]  out_status,
  output logic [6:0]  out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > 7) ? CW : 7;

  // ring pointer helpers
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
                                            input logic [AW-1:0] i);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, i};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    ptr_add = s[AW-1:0];
  endfunction

  // control and datapath registers
  state_t         state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  shifts_r, shifts_nxt;
  logic [63:0]    rem_r, rem_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [63:0]    out_value_r, out_value_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [6:0]     out_count_r, out_count_nxt;

  // memory port
  logic [63:0]    mem [DEPTH];
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [63:0]    mem_wdata;
  logic [63:0]    rd_data_r;

  // decode helpers
  logic           accept;
  logic           full, empty;
  logic [EW-1:0]  pos_e;
  logic [EW-1:0]  idx_e;
  logic [AW-1:0]  idx;
  logic           pos_bad;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign pos_e  = EW'(in_position);
  assign idx_e  = pos_e - EW'(1);
  assign idx    = idx_e[AW-1:0];
  assign pos_bad = (pos_e == '0) || (pos_e > EW'(count_r));

  // sequencer and memory control
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    shifts_nxt     = shifts_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = wr_ptr_r;
    mem_raddr      = rd_ptr_r;
    mem_wdata      = in_value;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_value_nxt  = '0;
          out_status_nxt = STAT_OK;
          case (in_mode)
            MODE_PUSH_BACK: begin
              if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ptr_add(head_r, count_r[AW-1:0]);
                count_nxt = count_r + CW'(1);
              end
              out_valid_nxt = 1'b1;
            end
            MODE_PUSH_FRONT: begin
              if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ptr_dec(head_r);
                head_nxt  = ptr_dec(head_r);
                count_nxt = count_r + CW'(1);
              end
              out_valid_nxt = 1'b1;
            end
            MODE_POP_BACK: begin
              if (empty) begin
                out_value_nxt  = INF_WORD;
                out_status_nxt = STAT_NOT_FOUND;
                out_valid_nxt  = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_add(head_r, count_r[AW-1:0] - AW'(1));
                shifts_nxt = '0;
                count_nxt  = count_r - CW'(1);
                state_nxt  = S_RD;
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                out_value_nxt  = INF_WORD;
                out_status_nxt = STAT_NOT_FOUND;
                out_valid_nxt  = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = head_r;
                head_nxt   = ptr_inc(head_r);
                shifts_nxt = '0;
                count_nxt  = count_r - CW'(1);
                state_nxt  = S_RD;
              end
            end
            MODE_POP_AT: begin
              if (pos_bad) begin
                out_value_nxt  = INF_WORD;
                out_status_nxt = STAT_NOT_FOUND;
                out_valid_nxt  = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_add(head_r, idx);
                wr_ptr_nxt = ptr_add(head_r, idx);
                shifts_nxt = count_r - CW'(1) - CW'(idx);
                count_nxt  = count_r - CW'(1);
                state_nxt  = S_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_count_nxt = 7'(count_nxt);
        end
      end

      // removed word arrives from memory
      S_RD: begin
        if (shifts_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data_r;
          out_status_nxt = STAT_OK;
          out_count_nxt  = 7'(count_r);
          state_nxt      = S_IDLE;
        end else begin
          rem_nxt    = rd_data_r;
          mem_re     = 1'b1;
          mem_raddr  = ptr_inc(wr_ptr_r);
          rd_ptr_nxt = ptr_inc(wr_ptr_r);
          state_nxt  = S_SHIFT;
        end
      end

      // move one trailing entry forward per cycle
      S_SHIFT: begin
        mem_we     = 1'b1;
        mem_waddr  = wr_ptr_r;
        mem_wdata  = rd_data_r;
        wr_ptr_nxt = rd_ptr_r;
        shifts_nxt = shifts_r - CW'(1);
        if (shifts_r != CW'(1)) begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_inc(rd_ptr_r);
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
        end else begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rem_r;
          out_status_nxt = STAT_OK;
          out_count_nxt  = 7'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and shift bookkeeping
  always_ff @(posedge clk) begin
    wr_ptr_r     <= wr_ptr_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    shifts_r     <= shifts_nxt;
    rem_r        <= rem_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_value_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_count_r;

  // checks
  `BDQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH),
    "entry count above capacity")
  `BDQ_ASSERT_NOW(a_no_rw_clash, clk, rst_n, mem_we && mem_re,
    mem_waddr != mem_raddr, "read and write to the same entry in one cycle")
  `BDQ_ASSERT_NOW(a_shift_left, clk, rst_n, state_r == S_SHIFT, shifts_r != '0,
    "shift state with nothing left to move")
  `BDQ_ASSERT_NEXT(a_push_result, clk, rst_n,
    accept && !full && (in_mode == MODE_PUSH_BACK || in_mode == MODE_PUSH_FRONT),
    out_valid && count_r == $past(count_r) + CW'(1), "insert did not complete")

endmodule
